// ===== rtl/snowcov_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Snow cover fraction update: shared package
// Field widths, fixed-point constants and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package snowcov_pkg;

   localparam int LEN_W   = 22;
   localparam int COV_W   = 17;
   localparam int WATER_W = 25;
   localparam int DEPTH_W = 24;
   localparam int QUO_W   = 16;
   localparam int CNT_W   = 4;

   localparam logic [COV_W-1:0]   FULL_COVER = 17'h10000;
   localparam logic [WATER_W-1:0] WATER_MAX  = 25'h0FFFFFF;
   localparam logic [WATER_W-1:0] WATER_MIN  = 25'h1000000;

   typedef struct packed {
      logic load;
      logic water;
      logic slope;
      logic div_step;
      logic out_load;
   } snowcov_cmd_type;

   typedef struct packed {
      logic go_slope;
      logic div_needed;
      logic out_free;
   } snowcov_status_type;

endpackage
`default_nettype wire

// ===== rtl/snowcov_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Snow cover fraction update: controller
// Sequences one word through the water step, on a melt step the slope step
// and where needed the sixteen restoring divide steps, then the hand-off to the output register.
// ----------------------------------------------------------------------------
module snowcov_ctrl (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  snowcov_pkg::snowcov_status_type  status,
   output snowcov_pkg::snowcov_cmd_type     cmd
);
   import snowcov_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WATER = 3'd1;
   localparam logic [2:0] S_SLOPE = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign req_stall = reset | (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_WATER;
            end
         end
         S_WATER: begin
            cmd.water = 1'b1;
            state_in  = status.go_slope ? S_SLOPE : S_DONE;
         end
         S_SLOPE: begin
            cmd.slope = 1'b1;
            if (status.div_needed) begin
               count_in = '1;
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

endmodule
`default_nettype wire

// ===== rtl/snowcov_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Snow cover fraction update: datapath
// Holds the captured word, the buried-distribution state, the slope limit,
// the restoring divider and the output register.
// ----------------------------------------------------------------------------
module snowcov_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  snowcov_pkg::snowcov_cmd_type       cmd,
   output snowcov_pkg::snowcov_status_type    status,
   input  wire                                csr_write_enable,
   input  wire  [snowcov_pkg::LEN_W-1:0]      csr_write_data,
   input  wire                                req_snowing,
   input  wire                                req_melting,
   input  wire  [snowcov_pkg::LEN_W-1:0]      req_new_water_equiv,
   input  wire  [snowcov_pkg::LEN_W-1:0]      req_prev_water_equiv,
   input  wire  [snowcov_pkg::LEN_W-1:0]      req_new_depth,
   input  wire  [snowcov_pkg::LEN_W-1:0]      req_prev_depth,
   input  wire  [snowcov_pkg::COV_W-1:0]      req_prev_coverage,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [snowcov_pkg::COV_W-1:0]      rsp_coverage,
   output logic                               rsp_buried_mode
);
   import snowcov_pkg::*;

   // Captured word.
   logic             snow_ff, melt_ff;
   logic [LEN_W-1:0] nw_ff, pw_ff, nd_ff, pd_ff;
   logic [COV_W-1:0] pc_ff, pc_in;

   // Persistent state.
   logic [LEN_W-1:0]          limit_ff, limit_in;
   logic                      mode_ff, mode_in;
   logic signed [WATER_W-1:0] water_ff, water_in;
   logic [COV_W-1:0]          cover_ff, cover_in;
   logic [DEPTH_W-1:0]        slope_ff, slope_in;
   logic [DEPTH_W-1:0]        peak_ff, peak_in;

   // Working registers.
   logic [COV_W-1:0]   cov_ff, cov_in;
   logic               use_div_ff, use_div_in;
   logic [DEPTH_W-1:0] rem_ff, rem_in;
   logic [DEPTH_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [COV_W-1:0] rsp_cov_ff, rsp_cov_in;
   logic             rsp_mode_ff, rsp_mode_in;

   // Water arithmetic.
   logic signed [LEN_W+1:0]   diff_c;
   logic signed [WATER_W+1:0] sum_c;
   logic signed [WATER_W-1:0] sat_c;
   logic                      deep_snow_c;

   // Slope arithmetic.
   logic [LEN_W:0]     two_pd_c;
   logic [DEPTH_W-1:0] slope_new_c;
   logic [DEPTH_W-1:0] slope_c;
   logic [DEPTH_W-1:0] peak_old_c;
   logic [DEPTH_W-1:0] peak_new_c;
   logic               shrink_c;
   logic               div_needed_c;

   // Divider step.
   logic [DEPTH_W:0] r2_c;
   logic             ge_c;
   logic [DEPTH_W:0] r2_sub_c;

   assign pc_in = (req_prev_coverage > FULL_COVER) ? FULL_COVER : req_prev_coverage;

   assign diff_c = $signed({2'b00, nw_ff}) - $signed({2'b00, pw_ff});
   assign sum_c  = {{2{water_ff[WATER_W-1]}}, water_ff}
                 + {{(WATER_W-LEN_W){diff_c[LEN_W+1]}}, diff_c};

   always_comb begin
      if (sum_c > $signed({{2{1'b0}}, WATER_MAX})) begin
         sat_c = $signed(WATER_MAX);
      end else if (sum_c < $signed({{2{1'b1}}, WATER_MIN})) begin
         sat_c = $signed(WATER_MIN);
      end else begin
         sat_c = sum_c[WATER_W-1:0];
      end
   end

   assign deep_snow_c = {nd_ff, 1'b0} >= {1'b0, limit_ff};

   assign two_pd_c    = {pd_ff, 1'b0};
   assign slope_new_c = (two_pd_c > {1'b0, limit_ff}) ? {2'b00, limit_ff}
                                                      : {1'b0, two_pd_c};
   assign slope_c     = (slope_ff == '0) ? slope_new_c : slope_ff;
   assign peak_old_c  = (slope_ff == '0) ? slope_new_c : peak_ff;
   assign peak_new_c  = {1'b0, nd_ff, 1'b0};
   assign shrink_c    = (peak_new_c < peak_old_c) || (peak_old_c == '0);
   assign div_needed_c = (water_ff == '0) && shrink_c && (slope_c != '0)
                       && (peak_new_c < slope_c);

   assign r2_c     = {rem_ff, 1'b0};
   assign ge_c     = r2_c >= {1'b0, dvs_ff};
   assign r2_sub_c = r2_c - {1'b0, dvs_ff};

   assign status.go_slope   = melt_ff && !snow_ff;
   assign status.div_needed = div_needed_c;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      limit_in   = csr_write_enable ? csr_write_data : limit_ff;
      mode_in    = mode_ff;
      water_in   = water_ff;
      cover_in   = cover_ff;
      slope_in   = slope_ff;
      peak_in    = peak_ff;
      cov_in     = cov_ff;
      use_div_in = use_div_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      quo_in     = quo_ff;

      if (cmd.load) begin
         use_div_in = 1'b0;
      end

      if (cmd.water) begin
         if (snow_ff) begin
            cov_in = FULL_COVER;
            if (mode_ff) begin
               if (water_ff == '0) begin
                  cover_in = pc_ff;
               end
               water_in = sat_c;
               if (deep_snow_c) begin
                  mode_in  = 1'b0;
                  water_in = '0;
                  slope_in = '0;
                  cover_in = FULL_COVER;
               end
            end else if (pc_ff < FULL_COVER) begin
               mode_in  = 1'b1;
               water_in = {{(WATER_W-LEN_W-2){diff_c[LEN_W+1]}}, diff_c};
            end
         end else if (melt_ff) begin
            cov_in = pc_ff;
            if ((water_ff > 0) && (nw_ff < pw_ff)) begin
               if (sat_c <= 0) begin
                  water_in = '0;
                  cov_in   = cover_ff;
                  cover_in = FULL_COVER;
               end else begin
                  water_in = sat_c;
               end
            end
         end else begin
            cov_in = pc_ff;
         end
      end

      if (cmd.slope && (water_ff == '0)) begin
         if (slope_ff == '0) begin
            mode_in = 1'b1;
         end
         slope_in = slope_c;
         peak_in  = peak_new_c;
         if (shrink_c) begin
            if (div_needed_c) begin
               use_div_in = 1'b1;
               rem_in     = peak_new_c;
               dvs_in     = slope_c;
               quo_in     = '0;
            end else begin
               cov_in = FULL_COVER;
            end
         end
      end

      if (cmd.div_step) begin
         rem_in = ge_c ? r2_sub_c[DEPTH_W-1:0] : r2_c[DEPTH_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge_c};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cov_in   = rsp_cov_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_cov_in   = use_div_ff ? {1'b0, quo_ff} : cov_ff;
         rsp_mode_in  = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LEN_W'(65536);
         mode_ff      <= 1'b0;
         water_ff     <= '0;
         cover_ff     <= FULL_COVER;
         slope_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         mode_ff      <= mode_in;
         water_ff     <= water_in;
         cover_ff     <= cover_in;
         slope_ff     <= slope_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         snow_ff <= req_snowing;
         melt_ff <= req_melting;
         nw_ff   <= req_new_water_equiv;
         pw_ff   <= req_prev_water_equiv;
         nd_ff   <= req_new_depth;
         pd_ff   <= req_prev_depth;
         pc_ff   <= pc_in;
      end
      cov_ff      <= cov_in;
      use_div_ff  <= use_div_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coverage    = rsp_cov_ff;
   assign rsp_buried_mode = rsp_mode_ff;

endmodule
`default_nettype wire

// ===== rtl/snow_cover_fraction_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Snow cover fraction update: top level
// Updates the snow-covered fraction once per time step, with a buried
// distribution for new snow over a partial pack.
//
//   Channel  Direction  Handshake            Word
//   req_     in         req_valid/req_stall  flags, water, depth, cover
//   rsp_     out        rsp_valid/rsp_stall  coverage, buried mode
//   csr_     in         csr_write_enable     slope limit
//
// An accepted word goes through the water step and, on a melt step, the
// slope step and, when a division is needed, the sixteen steps of the
// restoring divider, then waits for the output register to be free. Input
// is stalled until the result is in the output register; the next word is
// then taken while that result waits.
// Reset is synchronous; it returns the state and the slope limit to their
// reset values and empties the output register.
// ----------------------------------------------------------------------------
module snow_cover_fraction_update (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_enable,
   input  wire  [snowcov_pkg::LEN_W-1:0]  csr_write_data,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_snowing,
   input  wire                            req_melting,
   input  wire  [snowcov_pkg::LEN_W-1:0]  req_new_water_equiv,
   input  wire  [snowcov_pkg::LEN_W-1:0]  req_prev_water_equiv,
   input  wire  [snowcov_pkg::LEN_W-1:0]  req_new_depth,
   input  wire  [snowcov_pkg::LEN_W-1:0]  req_prev_depth,
   input  wire  [snowcov_pkg::COV_W-1:0]  req_prev_coverage,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [snowcov_pkg::COV_W-1:0]  rsp_coverage,
   output logic                           rsp_buried_mode
);
   import snowcov_pkg::*;

   snowcov_cmd_type    cmd;
   snowcov_status_type status;

   snowcov_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   snowcov_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_snowing          (req_snowing),
      .req_melting          (req_melting),
      .req_new_water_equiv  (req_new_water_equiv),
      .req_prev_water_equiv (req_prev_water_equiv),
      .req_new_depth        (req_new_depth),
      .req_prev_depth       (req_prev_depth),
      .req_prev_coverage    (req_prev_coverage),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_coverage         (rsp_coverage),
      .rsp_buried_mode      (rsp_buried_mode)
   );

endmodule
`default_nettype wire
